FILE: design/r2nv_pkg.sv
// r2nv_pkg: shared types and constants for the rgb to nv12 converter
// no dependencies; used by every module of the converter

package r2nv_pkg;

   // bt.601 studio range coefficients
   localparam logic [7:0] Y_COEF_R = 8'd66;
   localparam logic [7:0] Y_COEF_G = 8'd129;
   localparam logic [7:0] Y_COEF_B = 8'd25;
   localparam logic [7:0] U_COEF_R = 8'd38;   // subtracted
   localparam logic [7:0] U_COEF_G = 8'd74;   // subtracted
   localparam logic [7:0] U_COEF_B = 8'd112;
   localparam logic [7:0] V_COEF_R = 8'd112;
   localparam logic [7:0] V_COEF_G = 8'd94;   // subtracted
   localparam logic [7:0] V_COEF_B = 8'd18;   // subtracted
   localparam logic [7:0] LUMA_OFFSET = 8'd16;
   localparam logic [16:0] ROUND_HALF = 17'd128;
   // rounding plus 128 << 8 keeps the chroma sum non-negative
   localparam logic [16:0] CHROMA_BIAS = 17'd32896;

   localparam int LUMA_ADDR_W = 25;
   localparam int CHROMA_ADDR_W = 26;
   localparam int SIZE_W = 13;
   localparam int STRIDE_W = 14;

   // register map, word index
   localparam logic [1:0] REG_FRAME_WIDTH = 2'd0;
   localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
   localparam logic [1:0] REG_LINE_STRIDE = 2'd2;

   localparam logic [SIZE_W-1:0] FRAME_WIDTH_RESET = 13'd640;
   localparam logic [SIZE_W-1:0] FRAME_HEIGHT_RESET = 13'd480;
   localparam logic [STRIDE_W-1:0] LINE_STRIDE_RESET = 14'd640;

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } rgb_type;

   typedef struct packed {
      logic end_of_frame;
      logic [CHROMA_ADDR_W-1:0] chroma_addr;
      logic chroma_valid;
      logic [LUMA_ADDR_W-1:0] luma_addr;
   } addr_info_type;

   typedef struct packed {
      logic end_of_frame;
      logic chroma_valid;
      logic [7:0] chroma_v;
      logic [7:0] chroma_u;
      logic [CHROMA_ADDR_W-1:0] chroma_addr;
      logic [7:0] luma_right;
      logic [7:0] luma_left;
      logic [LUMA_ADDR_W-1:0] luma_addr;
   } rsp_item_type;

endpackage

FILE: design/r2nv_luma_lane.sv
// r2nv_luma_lane: two-stage luma conversion of one rgb pixel
// depends on r2nv_pkg

module r2nv_luma_lane (
   input  logic              clock,
   input  r2nv_pkg::rgb_type pixel,
   output logic [7:0]        luma
);

   logic [15:0] r_prod_ff, g_prod_ff, b_prod_ff;
   logic [16:0] sum;
   logic [7:0]  luma_ff, luma_in;

   always_ff @(posedge clock) begin
      r_prod_ff <= 16'(pixel.red) * 16'(r2nv_pkg::Y_COEF_R);
      g_prod_ff <= 16'(pixel.green) * 16'(r2nv_pkg::Y_COEF_G);
      b_prod_ff <= 16'(pixel.blue) * 16'(r2nv_pkg::Y_COEF_B);
      luma_ff <= luma_in;
   end

   always_comb begin
      sum = 17'(r_prod_ff) + 17'(g_prod_ff) + 17'(b_prod_ff) + r2nv_pkg::ROUND_HALF;
      luma_in = 8'(sum[16:8]) + r2nv_pkg::LUMA_OFFSET;
   end

   assign luma = luma_ff;

endmodule

FILE: design/r2nv_chroma_lane.sv
// r2nv_chroma_lane: two-stage u/v conversion of one rgb pixel
// depends on r2nv_pkg

module r2nv_chroma_lane (
   input  logic              clock,
   input  r2nv_pkg::rgb_type pixel,
   output logic [7:0]        chroma_u,
   output logic [7:0]        chroma_v
);

   logic [15:0] ur_ff, ug_ff, ub_ff, vr_ff, vg_ff, vb_ff;
   logic [16:0] u_sum, v_sum;
   logic [7:0]  u_ff, v_ff;

   always_ff @(posedge clock) begin
      ur_ff <= 16'(pixel.red) * 16'(r2nv_pkg::U_COEF_R);
      ug_ff <= 16'(pixel.green) * 16'(r2nv_pkg::U_COEF_G);
      ub_ff <= 16'(pixel.blue) * 16'(r2nv_pkg::U_COEF_B);
      vr_ff <= 16'(pixel.red) * 16'(r2nv_pkg::V_COEF_R);
      vg_ff <= 16'(pixel.green) * 16'(r2nv_pkg::V_COEF_G);
      vb_ff <= 16'(pixel.blue) * 16'(r2nv_pkg::V_COEF_B);
      u_ff <= u_sum[15:8];
      v_ff <= v_sum[15:8];
   end

   // positive terms plus bias always exceed the negative terms
   always_comb begin
      u_sum = 17'(ub_ff) + r2nv_pkg::CHROMA_BIAS - 17'(ur_ff) - 17'(ug_ff);
      v_sum = 17'(vr_ff) + r2nv_pkg::CHROMA_BIAS - 17'(vg_ff) - 17'(vb_ff);
   end

   assign chroma_u = u_ff;
   assign chroma_v = v_ff;

endmodule

FILE: design/r2nv_addr_gen.sv
// r2nv_addr_gen: column/row counters and two-stage plane address computation
// depends on r2nv_pkg

module r2nv_addr_gen #(
   parameter int MAX_WIDTH = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  advance,
   input  logic [r2nv_pkg::SIZE_W-1:0]           frame_width,
   input  logic [r2nv_pkg::SIZE_W-1:0]           frame_height,
   input  logic [r2nv_pkg::STRIDE_W-1:0]         line_stride,
   output r2nv_pkg::addr_info_type               addr_info
);

   localparam int PAIRS_MAX = (MAX_WIDTH + 1) / 2;
   localparam int COL_W = (PAIRS_MAX > 1) ? $clog2(PAIRS_MAX) : 1;
   localparam int ROW_W = $clog2(MAX_HEIGHT);
   localparam int LUMA_PROD_W = ROW_W + r2nv_pkg::STRIDE_W;
   localparam logic [13:0] MAX_W_LIM = 14'(MAX_WIDTH);
   localparam logic [13:0] MAX_H_LIM = 14'(MAX_HEIGHT);

   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [13:0] width_clamp, height_clamp, pairs, rows;
   logic        last_col, last_row;
   logic [13:0] chroma_row;
   logic [LUMA_PROD_W-1:0] luma_prod;
   logic [27:0] chroma_prod;

   logic [r2nv_pkg::LUMA_ADDR_W-1:0]   luma_prod_ff;
   logic [r2nv_pkg::CHROMA_ADDR_W-1:0] chroma_prod_ff;
   logic [COL_W:0] col2_ff;
   logic odd_ff, eof_ff;
   r2nv_pkg::addr_info_type info_ff, info_in;

   always_comb begin
      width_clamp = ({1'b0, frame_width} > MAX_W_LIM) ? MAX_W_LIM : {1'b0, frame_width};
      height_clamp = ({1'b0, frame_height} > MAX_H_LIM) ? MAX_H_LIM : {1'b0, frame_height};
      pairs = 14'(width_clamp + 14'd1) >> 1;
      if (pairs == 14'd0) begin
         pairs = 14'd1;
      end
      rows = height_clamp & ~14'd1;
      if (rows == 14'd0) begin
         rows = 14'd2;
      end
      last_col = (14'(col_ff) + 14'd1) >= pairs;
      last_row = (14'(row_ff) + 14'd1) >= rows;
      if (last_col) begin
         col_in = '0;
         row_in = last_row ? '0 : ROW_W'(row_ff + 1'b1);
      end else begin
         col_in = COL_W'(col_ff + 1'b1);
         row_in = row_ff;
      end
      chroma_row = 14'(row_ff >> 1) + {1'b0, frame_height};
      luma_prod = LUMA_PROD_W'(row_ff) * LUMA_PROD_W'(line_stride);
      chroma_prod = 28'(chroma_row) * 28'(line_stride);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (advance) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // products first, then the column offset is added
   always_ff @(posedge clock) begin
      luma_prod_ff <= r2nv_pkg::LUMA_ADDR_W'(luma_prod);
      chroma_prod_ff <= r2nv_pkg::CHROMA_ADDR_W'(chroma_prod);
      col2_ff <= {col_ff, 1'b0};
      odd_ff <= row_ff[0];
      eof_ff <= last_col && last_row;
      info_ff <= info_in;
   end

   always_comb begin
      info_in.luma_addr = luma_prod_ff + r2nv_pkg::LUMA_ADDR_W'(col2_ff);
      info_in.chroma_valid = odd_ff;
      info_in.chroma_addr = odd_ff ?
         chroma_prod_ff + r2nv_pkg::CHROMA_ADDR_W'(col2_ff) : '0;
      info_in.end_of_frame = eof_ff;
   end

   assign addr_info = info_ff;

endmodule

FILE: design/r2nv_merge.sv
// r2nv_merge: joins lane results into one response and queues it for output
// depends on r2nv_pkg

module r2nv_merge (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_accept,
   output logic                    req_ready,
   input  logic [7:0]              luma_left,
   input  logic [7:0]              luma_right,
   input  logic [7:0]              chroma_u,
   input  logic [7:0]              chroma_v,
   input  r2nv_pkg::addr_info_type addr_info,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output r2nv_pkg::rsp_item_type  rsp_item
);

   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   r2nv_pkg::rsp_item_type queue_ff [QUEUE_DEPTH];
   r2nv_pkg::rsp_item_type merged;
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [PTR_W:0]   count_ff, count_in;
   logic             stage_a_ff, stage_b_ff;
   logic             push, pop;
   logic [PTR_W+1:0] pending;

   always_comb begin
      merged.luma_addr = addr_info.luma_addr;
      merged.luma_left = luma_left;
      merged.luma_right = luma_right;
      merged.chroma_addr = addr_info.chroma_addr;
      merged.chroma_u = addr_info.chroma_valid ? chroma_u : 8'd0;
      merged.chroma_v = addr_info.chroma_valid ? chroma_v : 8'd0;
      merged.chroma_valid = addr_info.chroma_valid;
      merged.end_of_frame = addr_info.end_of_frame;
      push = stage_b_ff;
      pop = rsp_valid && rsp_ready;
      count_in = count_ff + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
      // requests in the pipeline count against queue space
      pending = (PTR_W+2)'(count_ff) + (PTR_W+2)'(stage_a_ff) + (PTR_W+2)'(stage_b_ff);
      req_ready = pending < (PTR_W+2)'(QUEUE_DEPTH);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_a_ff <= 1'b0;
         stage_b_ff <= 1'b0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         stage_a_ff <= req_accept;
         stage_b_ff <= stage_a_ff;
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= PTR_W'(wr_ptr_ff + 1'b1);
         end
         if (pop) begin
            rd_ptr_ff <= PTR_W'(rd_ptr_ff + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= merged;
      end
   end

   assign rsp_valid = count_ff != '0;
   assign rsp_item = queue_ff[rd_ptr_ff];

endmodule

FILE: design/rgb32_to_nv12_converter_top.sv
// rgb32_to_nv12_converter_top: stream rgb pixel pairs in, nv12 plane writes out
// depends on r2nv_pkg, r2nv_luma_lane, r2nv_chroma_lane, r2nv_addr_gen, r2nv_merge

// Takes one horizontal pair of RGB pixels per clock in raster order and returns,
// for each pair, two BT.601 studio-range luma bytes with their luma plane offset;
// on odd rows the response also carries the U/V pair of the left pixel and its
// offset in the interleaved chroma plane that starts at row frame_height. A
// request is accepted every cycle while the response side keeps up; each response
// goes through the product stage, sum stage and output queue. Under backpressure the
// four-entry output queue, shared with the two pipeline stages, sets how many
// requests are taken before req_tready drops. The user must write frame size and
// stride over the csr port only while no request is in flight; the block does not
// enforce this. The frame ends on the last pair of the last even-numbered row pair.

module rgb32_to_nv12_converter_top #(
   parameter int MAX_WIDTH = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // left_red, left_green, left_blue, right_red, right_green, right_blue
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // luma_addr, luma_left, luma_right, chroma_addr, chroma_u, chroma_v, zero pad
   output logic [87:0] rsp_tdata,
   // chroma_valid
   output logic        rsp_tuser,
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [r2nv_pkg::SIZE_W-1:0]   frame_width_ff, frame_height_ff;
   logic [r2nv_pkg::STRIDE_W-1:0] line_stride_ff;
   logic                          csr_write;
   logic                          req_accept;
   r2nv_pkg::rgb_type             left_pixel, right_pixel;
   logic [7:0]                    luma_left, luma_right, chroma_u, chroma_v;
   r2nv_pkg::addr_info_type       addr_info;
   r2nv_pkg::rsp_item_type        rsp_item;

   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff <= r2nv_pkg::FRAME_WIDTH_RESET;
         frame_height_ff <= r2nv_pkg::FRAME_HEIGHT_RESET;
         line_stride_ff <= r2nv_pkg::LINE_STRIDE_RESET;
      end else if (csr_write) begin
         case (csr_paddr[3:2])
            r2nv_pkg::REG_FRAME_WIDTH: begin
               frame_width_ff <= csr_pwdata[r2nv_pkg::SIZE_W-1:0];
            end
            r2nv_pkg::REG_FRAME_HEIGHT: begin
               frame_height_ff <= csr_pwdata[r2nv_pkg::SIZE_W-1:0];
            end
            r2nv_pkg::REG_LINE_STRIDE: begin
               line_stride_ff <= csr_pwdata[r2nv_pkg::STRIDE_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         r2nv_pkg::REG_FRAME_WIDTH:  csr_prdata = 32'(frame_width_ff);
         r2nv_pkg::REG_FRAME_HEIGHT: csr_prdata = 32'(frame_height_ff);
         r2nv_pkg::REG_LINE_STRIDE:  csr_prdata = 32'(line_stride_ff);
         default:                    csr_prdata = 32'd0;
      endcase
   end

   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      left_pixel.red = req_tdata[7:0];
      left_pixel.green = req_tdata[15:8];
      left_pixel.blue = req_tdata[23:16];
      right_pixel.red = req_tdata[31:24];
      right_pixel.green = req_tdata[39:32];
      right_pixel.blue = req_tdata[47:40];
   end

   r2nv_luma_lane u_luma_left (
      .clock (clock),
      .pixel (left_pixel),
      .luma  (luma_left)
   );

   r2nv_luma_lane u_luma_right (
      .clock (clock),
      .pixel (right_pixel),
      .luma  (luma_right)
   );

   r2nv_chroma_lane u_chroma (
      .clock    (clock),
      .pixel    (left_pixel),
      .chroma_u (chroma_u),
      .chroma_v (chroma_v)
   );

   r2nv_addr_gen #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_addr_gen (
      .clock        (clock),
      .reset        (reset),
      .advance      (req_accept),
      .frame_width  (frame_width_ff),
      .frame_height (frame_height_ff),
      .line_stride  (line_stride_ff),
      .addr_info    (addr_info)
   );

   r2nv_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req_ready  (req_tready),
      .luma_left  (luma_left),
      .luma_right (luma_right),
      .chroma_u   (chroma_u),
      .chroma_v   (chroma_v),
      .addr_info  (addr_info),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_item   (rsp_item)
   );

   assign rsp_tdata = {5'd0, rsp_item.chroma_v, rsp_item.chroma_u, rsp_item.chroma_addr,
                       rsp_item.luma_right, rsp_item.luma_left, rsp_item.luma_addr};
   assign rsp_tuser = rsp_item.chroma_valid;
   assign rsp_tlast = rsp_item.end_of_frame;

endmodule

FILE: verif/rgb32_to_nv12_converter_top_test.sv
// rgb32_to_nv12_converter_top_test: self-checking bench for the rgb to nv12 converter
// needs r2nv_pkg and rgb32_to_nv12_converter_top; plane writes are predicted in-bench
// and compared field by field under random stalls on both stream sides

`timescale 1ns / 100ps

module rgb32_to_nv12_converter_top_test;

   localparam int MAX_W = 4096;
   localparam int MAX_H = 4096;
   localparam int HOLD_STEP = 900;

   // red sits in the low byte of each pixel
   typedef struct packed {
      r2nv_pkg::rgb_type right;
      r2nv_pkg::rgb_type left;
   } pixel_pair_type;

   typedef struct packed {
      logic [r2nv_pkg::LUMA_ADDR_W-1:0] luma_addr;
      logic [7:0] luma_left;
      logic [7:0] luma_right;
      logic chroma_valid;
      logic [r2nv_pkg::CHROMA_ADDR_W-1:0] chroma_addr;
      logic [7:0] chroma_u;
      logic [7:0] chroma_v;
      logic end_of_frame;
   } nv12_write_type;

   typedef enum logic {STEP_PAIR, STEP_CSR} step_kind_type;

   typedef struct {
      step_kind_type kind;
      logic [1:0] index;
      logic [31:0] value;
      pixel_pair_type pixels;
      bit typed;
      nv12_write_type want;
   } dir_step_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [47:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [87:0] rsp_tdata;
   logic rsp_tuser;
   logic rsp_tlast;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [3:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   // predictor copy of the registers and counters
   logic [r2nv_pkg::SIZE_W-1:0] cfg_width = r2nv_pkg::FRAME_WIDTH_RESET;
   logic [r2nv_pkg::SIZE_W-1:0] cfg_height = r2nv_pkg::FRAME_HEIGHT_RESET;
   logic [r2nv_pkg::STRIDE_W-1:0] cfg_stride = r2nv_pkg::LINE_STRIDE_RESET;
   int pair_col = 0;
   int row_idx = 0;

   nv12_write_type pending_writes[$];
   dir_step_type directed_steps[$];
   int accepted = 0;
   int mismatches = 0;
   bit steady = 1'b0;

   rgb32_to_nv12_converter_top u_top (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [7:0] luma_byte(input int r, input int g, input int b);
      int sum;
      sum = ((66 * r + 129 * g + 25 * b + 128) >> 8) + 16;
      return sum[7:0];
   endfunction

   // floor shift done on a value biased by 128 << 8
   function automatic logic [7:0] chroma_byte(input int x);
      int biased;
      biased = x + 32768;
      return biased[15:8];
   endfunction

   function automatic nv12_write_type convert_pair(input pixel_pair_type p);
      int w, h, pairs, rows, lr, lg, lb;
      bit odd, last_col, last_row;
      nv12_write_type res;
      w = (int'(cfg_width) > MAX_W) ? MAX_W : int'(cfg_width);
      h = (int'(cfg_height) > MAX_H) ? MAX_H : int'(cfg_height);
      pairs = (w + 1) >> 1;
      rows = h & ~1;
      if (pairs == 0) begin
         pairs = 1;
      end
      if (rows == 0) begin
         rows = 2;
      end
      odd = (row_idx % 2) == 1;
      lr = int'(p.left.red);
      lg = int'(p.left.green);
      lb = int'(p.left.blue);
      res = '0;
      res.luma_addr = r2nv_pkg::LUMA_ADDR_W'(row_idx * int'(cfg_stride) + 2 * pair_col);
      res.luma_left = luma_byte(lr, lg, lb);
      res.luma_right = luma_byte(int'(p.right.red), int'(p.right.green),
                                 int'(p.right.blue));
      res.chroma_valid = odd;
      if (odd) begin
         // chroma plane starts at the height as written, not the clamped one
         res.chroma_addr = r2nv_pkg::CHROMA_ADDR_W'(((row_idx >> 1) + int'(cfg_height))
                                                    * int'(cfg_stride) + 2 * pair_col);
         res.chroma_u = chroma_byte(-38 * lr - 74 * lg + 112 * lb + 128);
         res.chroma_v = chroma_byte(112 * lr - 94 * lg - 18 * lb + 128);
      end
      last_col = pair_col + 1 >= pairs;
      last_row = row_idx + 1 >= rows;
      res.end_of_frame = last_col && last_row;
      if (last_col) begin
         pair_col = 0;
         row_idx = last_row ? 0 : row_idx + 1;
      end else begin
         pair_col++;
      end
      return res;
   endfunction

   function automatic nv12_write_type make_write(input int la, input int yl, input int yr,
                                                 input bit cv, input int ca, input int u,
                                                 input int v, input bit eof);
      nv12_write_type res;
      res.luma_addr = r2nv_pkg::LUMA_ADDR_W'(la);
      res.luma_left = 8'(yl);
      res.luma_right = 8'(yr);
      res.chroma_valid = cv;
      res.chroma_addr = r2nv_pkg::CHROMA_ADDR_W'(ca);
      res.chroma_u = 8'(u);
      res.chroma_v = 8'(v);
      res.end_of_frame = eof;
      return res;
   endfunction

   function automatic dir_step_type pair_row(input pixel_pair_type p, input bit typed = 1'b0,
                                             input nv12_write_type want = '0);
      dir_step_type st;
      st.kind = STEP_PAIR;
      st.index = '0;
      st.value = '0;
      st.pixels = p;
      st.typed = typed;
      st.want = want;
      return st;
   endfunction

   function automatic dir_step_type csr_row(input logic [1:0] index,
                                            input logic [31:0] value);
      dir_step_type st;
      st.kind = STEP_CSR;
      st.index = index;
      st.value = value;
      st.pixels = '0;
      st.typed = 1'b0;
      st.want = '0;
      return st;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t ns: %s", $time, msg);
      mismatches++;
   endtask

   // register writes only once every request has come back
   task automatic write_csr(input logic [1:0] index, input logic [31:0] value);
      req_tvalid <= 1'b0;
      while (pending_writes.size() != 0) begin
         @(posedge clock);
      end
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (index)
         r2nv_pkg::REG_FRAME_WIDTH: cfg_width = value[r2nv_pkg::SIZE_W-1:0];
         r2nv_pkg::REG_FRAME_HEIGHT: cfg_height = value[r2nv_pkg::SIZE_W-1:0];
         r2nv_pkg::REG_LINE_STRIDE: cfg_stride = value[r2nv_pkg::STRIDE_W-1:0];
         default: ;
      endcase
   endtask

   task automatic send_pair(input pixel_pair_type p, input bit typed = 1'b0,
                            input nv12_write_type want = '0);
      nv12_write_type predicted;
      if (csr_psel) begin
         csr_psel <= 1'b0;
         csr_penable <= 1'b0;
      end
      while (!steady && $urandom_range(99) < 27) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= p;
      do @(posedge clock); while (!req_tready);
      predicted = convert_pair(p);
      pending_writes.push_back(typed ? want : predicted);
      accepted++;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
   end

   // response side: random stalls plus an occasional long hold-off
   initial begin
      int hold_left;
      int next_hold;
      hold_left = 0;
      next_hold = 150;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_tready <= 1'b0;
         end else if (hold_left != 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (accepted >= next_hold) begin
            rsp_tready <= 1'b0;
            hold_left = 80;
            next_hold += HOLD_STEP;
         end else begin
            rsp_tready <= steady || ($urandom_range(99) >= 27);
         end
      end
   end

   always @(posedge clock) begin
      nv12_write_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.luma_addr = rsp_tdata[24:0];
         got.luma_left = rsp_tdata[32:25];
         got.luma_right = rsp_tdata[40:33];
         got.chroma_addr = rsp_tdata[66:41];
         got.chroma_u = rsp_tdata[74:67];
         got.chroma_v = rsp_tdata[82:75];
         got.chroma_valid = rsp_tuser;
         got.end_of_frame = rsp_tlast;
         if (pending_writes.size() == 0) begin
            report_mismatch("response with no request outstanding");
         end else begin
            want = pending_writes.pop_front();
            if (got.luma_addr !== want.luma_addr)
               report_mismatch($sformatf("luma_addr got %0d want %0d",
                                         got.luma_addr, want.luma_addr));
            if (got.luma_left !== want.luma_left)
               report_mismatch($sformatf("luma_left got %0d want %0d",
                                         got.luma_left, want.luma_left));
            if (got.luma_right !== want.luma_right)
               report_mismatch($sformatf("luma_right got %0d want %0d",
                                         got.luma_right, want.luma_right));
            if (got.chroma_valid !== want.chroma_valid)
               report_mismatch($sformatf("chroma_valid got %0d want %0d",
                                         got.chroma_valid, want.chroma_valid));
            if (got.chroma_addr !== want.chroma_addr)
               report_mismatch($sformatf("chroma_addr got %0d want %0d",
                                         got.chroma_addr, want.chroma_addr));
            if (got.chroma_u !== want.chroma_u)
               report_mismatch($sformatf("chroma_u got %0d want %0d",
                                         got.chroma_u, want.chroma_u));
            if (got.chroma_v !== want.chroma_v)
               report_mismatch($sformatf("chroma_v got %0d want %0d",
                                         got.chroma_v, want.chroma_v));
            if (got.end_of_frame !== want.end_of_frame)
               report_mismatch($sformatf("end_of_frame got %0d want %0d",
                                         got.end_of_frame, want.end_of_frame));
         end
      end
   end

   initial begin
      #5_000_000;
      $display("rgb32_to_nv12_converter_top_test: errors");
      $finish;
   end

   initial begin
      logic [47:0] raw;
      logic [12:0] w, h;
      logic [13:0] s;
      int items, sent, phase;
      int extremes[6];

      extremes = '{0, 1, 2, 4096, 4097, 8191};

      // default 640 x 480 frame straight out of reset
      directed_steps.push_back(pair_row(48'h000000_000000, 1'b1,
                                        make_write(0, 16, 16, 0, 0, 0, 0, 0)));
      directed_steps.push_back(pair_row(48'hFFFFFF_FFFFFF, 1'b1,
                                        make_write(2, 235, 235, 0, 0, 0, 0, 0)));
      directed_steps.push_back(pair_row(48'h000000_FFFFFF, 1'b1,
                                        make_write(4, 235, 16, 0, 0, 0, 0, 0)));
      // shrink mid-row: column now past the last pair, odd height drops the last row
      directed_steps.push_back(csr_row(r2nv_pkg::REG_FRAME_WIDTH, 32'd2));
      directed_steps.push_back(csr_row(r2nv_pkg::REG_FRAME_HEIGHT, 32'd3));
      directed_steps.push_back(csr_row(r2nv_pkg::REG_LINE_STRIDE, 32'd2));
      directed_steps.push_back(pair_row(48'h123456_ABCDEF));
      directed_steps.push_back(pair_row(48'h000000_0000FF, 1'b1,
                                        make_write(2, 82, 16, 1, 6, 90, 240, 1)));
      directed_steps.push_back(pair_row(48'hFFFFFF_FFFFFF, 1'b1,
                                        make_write(0, 235, 235, 0, 0, 0, 0, 0)));
      directed_steps.push_back(pair_row(48'h000000_FF0000));
      // degenerate size: zero pairs and zero rows
      directed_steps.push_back(csr_row(r2nv_pkg::REG_FRAME_WIDTH, 32'd0));
      directed_steps.push_back(csr_row(r2nv_pkg::REG_FRAME_HEIGHT, 32'd1));
      directed_steps.push_back(pair_row(48'h00FF00_00FF00));
      directed_steps.push_back(pair_row(48'h00FF00_FF00FF));
      // oversized height with widest stride wraps the chroma address
      directed_steps.push_back(csr_row(r2nv_pkg::REG_FRAME_HEIGHT, 32'd8191));
      directed_steps.push_back(csr_row(r2nv_pkg::REG_LINE_STRIDE, 32'd16383));
      directed_steps.push_back(pair_row(48'hFF00FF_00FF00));
      directed_steps.push_back(pair_row(48'h0000FF_FFFF00));
      directed_steps.push_back(csr_row(r2nv_pkg::REG_FRAME_WIDTH, 32'd8191));
      directed_steps.push_back(pair_row(48'h7F8001_FE8040));
      directed_steps.push_back(pair_row(48'h55AA55_AA55AA));

      @(posedge clock);
      while (reset) begin
         @(posedge clock);
      end

      foreach (directed_steps[k]) begin
         if (directed_steps[k].kind == STEP_CSR) begin
            write_csr(directed_steps[k].index, directed_steps[k].value);
         end else begin
            send_pair(directed_steps[k].pixels, directed_steps[k].typed,
                      directed_steps[k].want);
         end
      end

      // first phase runs one pair per row down a tall frame so luma addresses wrap
      sent = 0;
      phase = 0;
      while (sent < 2150) begin
         if (phase == 0) begin
            w = 13'($urandom_range(2));
            h = 13'd8191;
            s = 14'd16383;
            items = 2060;
         end else begin
            case ($urandom_range(3))
               0: begin
                  w = 13'($urandom_range(8191));
                  h = 13'($urandom_range(8191));
                  s = 14'($urandom_range(16383));
               end
               1: begin
                  w = 13'(extremes[$urandom_range(5)]);
                  h = 13'(extremes[$urandom_range(5)]);
                  s = $urandom_range(1) ? 14'd16383 : 14'd0;
               end
               default: begin
                  w = 13'($urandom_range(12));
                  h = 13'($urandom_range(9));
                  s = 14'($urandom_range(2, 64));
               end
            endcase
            items = $urandom_range(10, 40);
         end
         // junk above the field widths must be dropped
         write_csr(r2nv_pkg::REG_FRAME_WIDTH, ($urandom & 32'hFFFF_E000) | 32'(w));
         write_csr(r2nv_pkg::REG_FRAME_HEIGHT, ($urandom & 32'hFFFF_E000) | 32'(h));
         write_csr(r2nv_pkg::REG_LINE_STRIDE, ($urandom & 32'hFFFF_C000) | 32'(s));
         for (int i = 0; i < items; i++) begin
            steady = (phase == 0) && (i >= 300) && (i < 700);
            for (int c = 0; c < 6; c++) begin
               if ($urandom_range(9) == 0) begin
                  raw[8*c +: 8] = $urandom_range(1) ? 8'hFF : 8'h00;
               end else begin
                  raw[8*c +: 8] = 8'($urandom_range(255));
               end
            end
            send_pair(raw);
            sent++;
         end
         steady = 1'b0;
         phase++;
      end

      req_tvalid <= 1'b0;
      while (pending_writes.size() != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("rgb32_to_nv12_converter_top_test: clean");
      end else begin
         $display("rgb32_to_nv12_converter_top_test: errors");
      end
      $finish;
   end

endmodule
